// ----- sv/sfra_pkg.sv -----
// Shared types and constants for the framed receiver with ack/nack reply.
package sfra_pkg;

  // Item kinds carried from the front to the back
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // One classified input item as it sits in the queue
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } item_t;

  // Queue handshake between front and back
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_BUF_CAP     = 2'd0,
    REG_READ_TMO    = 2'd1,
    REG_FLUSH_QUIET = 2'd2
  } cfg_idx_t;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPLY   = 1'b1;

  // Reply byte bits and sequence width
  localparam logic [5:0] SEQ_MASK  = 6'h3F;
  localparam logic [7:0] ACK_BITS  = 8'hC0;
  localparam logic [7:0] NACK_BITS = 8'h80;

  // Register reset values
  localparam logic [7:0] BUF_CAP_RST     = 8'hFF;
  localparam logic [7:0] READ_TMO_RST    = 8'd20;
  localparam logic [7:0] FLUSH_QUIET_RST = 8'd10;

  // Silence counter saturation
  localparam logic [7:0] SIL_MAX = 8'hFF;

  // Queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

endpackage

// ----- sv/sfra_if.sv -----
// Valid/ready channel interfaces for input items and result items.
interface sfra_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface sfra_out_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] out_byte;
  logic       frame_ok;
  logic [7:0] frame_length;

  modport source (output valid, output out_kind, output out_byte, output frame_ok,
                  output frame_length, input ready);
  modport sink   (input valid, input out_kind, input out_byte, input frame_ok,
                  input frame_length, output ready);
endinterface

// ----- sv/sfra_front.sv -----
// Front part: accepts input items, classifies them and queues them for the back.
module sfra_front
  import sfra_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  sfra_in_if.sink     in_ch,
  output q_head_t     head,
  input  logic        pop
);

  item_t             q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              push;
  logic              pop_ok;
  item_t             new_item;

  // Classify the incoming item
  always_comb begin
    new_item.op   = in_ch.req_type ? OP_TICK : OP_BYTE;
    new_item.data = in_ch.req_type ? 8'd0 : in_ch.rx_byte;
  end

  assign in_ch.ready = (cnt_r != QCNT_W'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign pop_ok      = pop && (cnt_r != '0);

  assign head.valid = (cnt_r != '0);
  assign head.item  = q_mem[rd_ptr_r];

  // Store item at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= new_item;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      unique case ({push, pop_ok})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QDEPTH))
    else $error("queue fill count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("queue popped while empty");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == QCNT_W'(QDEPTH)) |-> !push)
    else $error("item taken while queue full");
`endif

endmodule

// ----- sv/sfra_back.sv -----
// Back part: frame state machine, checksum, reply generation and output register.
module sfra_back
  import sfra_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 255
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  q_head_t               head,
  output logic                  pop,
  sfra_out_if.source            out_ch
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SEQ     = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_SUM_HI  = 3'd3,
    PH_SUM_LO  = 3'd4,
    PH_FLUSH   = 3'd5
  } phase_t;

  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  // Configuration
  logic [7:0] buf_cap_r;
  logic [7:0] read_tmo_r;
  logic [7:0] flush_quiet_r;

  // Frame state
  phase_t      phase_r,   phase_nxt;
  logic [5:0]  seq_r,     seq_nxt;
  logic [7:0]  flen_r,    flen_nxt;
  logic [7:0]  pcnt_r,    pcnt_nxt;
  logic [8:0]  pos_r,     pos_nxt;
  logic [15:0] sum_r,     sum_nxt;
  logic [7:0]  pend_r,    pend_nxt;
  logic [7:0]  sil_r,     sil_nxt;

  // Output register
  logic        ovalid_r;
  logic        okind_r,   okind_nxt;
  logic [7:0]  obyte_r,   obyte_nxt;
  logic        ook_r,     ook_nxt;
  logic [7:0]  olen_r,    olen_nxt;
  logic        emit;

  logic        go;
  logic [7:0]  b;
  logic [7:0]  sil_inc;
  logic [8:0]  add_pos;
  logic [15:0] add_base;
  logic [15:0] prod;
  logic [15:0] add_sum;
  logic [7:0]  pcnt_inc;
  logic        reply_ok;

  // Take the head item when the output register can take a result
  assign go  = head.valid && (!ovalid_r || out_ch.ready);
  assign pop = go;
  assign b   = head.item.data;

  // Checksum step: one multiply-accumulate per byte
  assign add_pos  = (phase_r == PH_IDLE) ? 9'd1 : pos_r + 9'd1;
  assign add_base = (phase_r == PH_IDLE) ? 16'd0 : sum_r;
  assign prod     = 16'(b) * 16'(add_pos);
  assign add_sum  = add_base + prod;

  assign sil_inc  = (sil_r == SIL_MAX) ? sil_r : sil_r + 8'd1;
  assign pcnt_inc = pcnt_r + 8'd1;
  assign reply_ok = ((pend_r & ACK_BITS) == ACK_BITS);

  // Next-state logic
  always_comb begin
    phase_nxt = phase_r;
    seq_nxt   = seq_r;
    flen_nxt  = flen_r;
    pcnt_nxt  = pcnt_r;
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    pend_nxt  = pend_r;
    sil_nxt   = sil_r;
    emit      = 1'b0;
    okind_nxt = KIND_PAYLOAD;
    obyte_nxt = b;
    ook_nxt   = 1'b0;
    olen_nxt  = 8'd0;

    if (head.item.op == OP_TICK) begin
      priority if (phase_r == PH_IDLE) begin
        // idle ticks do nothing
      end else if (phase_r == PH_FLUSH) begin
        if (sil_inc >= flush_quiet_r) begin
          emit      = 1'b1;
          okind_nxt = KIND_REPLY;
          obyte_nxt = pend_r;
          ook_nxt   = reply_ok;
          olen_nxt  = reply_ok ? flen_r : 8'd0;
          phase_nxt = PH_IDLE;
          sil_nxt   = 8'd0;
        end else begin
          sil_nxt = sil_inc;
        end
      end else begin
        if (sil_inc >= read_tmo_r) begin
          phase_nxt = PH_FLUSH;
          sil_nxt   = 8'd0;
        end else begin
          sil_nxt = sil_inc;
        end
      end
    end else begin
      sil_nxt = 8'd0;
      unique case (phase_r)
        PH_IDLE: begin
          flen_nxt = b;
          pend_nxt = NACK_BITS | {2'b00, seq_r};
          pcnt_nxt = 8'd0;
          if (b > MAX_LEN || b > buf_cap_r) begin
            sum_nxt   = 16'd0;
            pos_nxt   = 9'd0;
            phase_nxt = PH_FLUSH;
          end else begin
            sum_nxt   = add_sum;
            pos_nxt   = add_pos;
            phase_nxt = PH_SEQ;
          end
        end
        PH_SEQ: begin
          if (b != {2'b00, seq_r}) begin
            if (b <= {2'b00, SEQ_MASK}) begin
              seq_nxt = b[5:0];
            end
            phase_nxt = PH_FLUSH;
          end else begin
            sum_nxt   = add_sum;
            pos_nxt   = add_pos;
            phase_nxt = (flen_r == 8'd0) ? PH_SUM_HI : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum_nxt   = add_sum;
          pos_nxt   = add_pos;
          pcnt_nxt  = pcnt_inc;
          if (pcnt_inc >= flen_r) begin
            phase_nxt = PH_SUM_HI;
          end
          emit = 1'b1;
        end
        PH_SUM_HI: begin
          phase_nxt = (sum_r[15:8] != b) ? PH_FLUSH : PH_SUM_LO;
        end
        PH_SUM_LO: begin
          if (sum_r[7:0] == b) begin
            pend_nxt = pend_r | ACK_BITS;
            seq_nxt  = (seq_r + 6'd1) & SEQ_MASK;
          end
          phase_nxt = PH_FLUSH;
        end
        default: begin
          // drop bytes while discarding
          phase_nxt = PH_FLUSH;
        end
      endcase
    end
  end

  // Hold state, configuration and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_cap_r     <= BUF_CAP_RST;
      read_tmo_r    <= READ_TMO_RST;
      flush_quiet_r <= FLUSH_QUIET_RST;
      phase_r       <= PH_IDLE;
      seq_r         <= 6'd0;
      flen_r        <= 8'd0;
      pcnt_r        <= 8'd0;
      pos_r         <= 9'd0;
      sum_r         <= 16'd0;
      pend_r        <= 8'd0;
      sil_r         <= 8'd0;
      ovalid_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == REG_BUF_CAP)     buf_cap_r     <= cfg_wdata;
        if (cfg_idx == REG_READ_TMO)    read_tmo_r    <= cfg_wdata;
        if (cfg_idx == REG_FLUSH_QUIET) flush_quiet_r <= cfg_wdata;
      end
      if (go) begin
        phase_r <= phase_nxt;
        seq_r   <= seq_nxt;
        flen_r  <= flen_nxt;
        pcnt_r  <= pcnt_nxt;
        pos_r   <= pos_nxt;
        sum_r   <= sum_nxt;
        pend_r  <= pend_nxt;
        sil_r   <= sil_nxt;
      end
      if (go && emit) begin
        ovalid_r <= 1'b1;
        okind_r  <= okind_nxt;
        obyte_r  <= obyte_nxt;
        ook_r    <= ook_nxt;
        olen_r   <= olen_nxt;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = ovalid_r;
  assign out_ch.out_kind     = okind_r;
  assign out_ch.out_byte     = obyte_r;
  assign out_ch.frame_ok     = ook_r;
  assign out_ch.frame_length = olen_r;

`ifndef SYNTHESIS
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (sil_r == 8'd0))
    else $error("silence count not cleared in idle");

  a_payload_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && okind_r == KIND_PAYLOAD) |-> (!ook_r && olen_r == 8'd0))
    else $error("payload result carries frame status");

  a_ack_code: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && ook_r) |-> (okind_r == KIND_REPLY && obyte_r[7:6] == 2'b11))
    else $error("accepted frame without ack code");
`endif

endmodule

// ----- sv/spi_frame_receiver_acker_unit.sv -----
// Top level of the framed receiver with ack/nack reply.
//
// Usage: the input channel carries one item per handshake, either a received
// byte (req_type 0) or a one-millisecond tick (req_type 1). The result channel
// delivers payload bytes as they arrive (out_kind 0) and, after a frame ends
// or fails and a quiet window of ticks has passed, one reply byte (out_kind 1):
// ACK 0xC0|seq with frame_ok and frame_length, or NACK 0x80|seq.
// The write port sets buffer_capacity, read_timeout_ms and flush_quiet_ms;
// write it only while no items are in flight.
// Throughput: one item per cycle unless a pending result is stalled by a low
// out_ch.ready; the single 8x9 multiply-accumulate in the back updates the checksum.
// Results: a result is valid in the cycle after the back takes the item; an
// accepted item passes through the four-entry queue and then the output
// register before it reaches the result channel.
// Reset: synchronous, clears the queue, the output register and all frame
// state; registers return to 255, 20 and 10. No clearing pass is needed.
// Stalls: when out_ch.ready is low while a result is pending, it holds, the back stops,
// and the input keeps being taken until the queue is full.
module spi_frame_receiver_acker_unit
  import sfra_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = 255
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  sfra_in_if.sink               in_ch,
  sfra_out_if.source            out_ch
);

  q_head_t head;
  logic    pop;

  // Accept and queue items
  sfra_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .head  (head),
    .pop   (pop)
  );

  // Run the frame protocol
  sfra_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .pop       (pop),
    .out_ch    (out_ch)
  );

endmodule
